>>> rtl/dpsm_pkg.sv
// Package for the drive power state machine: state codes, status word bit
// positions, request and result types. Depends on nothing.
`default_nettype none

package dpsm_pkg;

  // Drive power states, encoded as the reported state code.
  typedef enum logic [3:0] {
    ST_START       = 4'd0,
    ST_NOT_READY   = 4'd1,
    ST_DISABLED    = 4'd2,
    ST_READY       = 4'd3,
    ST_SWITCHED_ON = 4'd4,
    ST_OP_ENABLED  = 4'd5,
    ST_QSTOP       = 4'd6,
    ST_FAULT_REACT = 4'd7,
    ST_FAULT       = 4'd8
  } state_t;

  // Status word bits as held in the six-bit status register.
  localparam int unsigned StatusWidth = 6;
  typedef logic [StatusWidth-1:0] status_t;

  localparam status_t SB_RTSO  = 6'b00_0001;
  localparam status_t SB_SO    = 6'b00_0010;
  localparam status_t SB_OE    = 6'b00_0100;
  localparam status_t SB_FAULT = 6'b00_1000;
  localparam status_t SB_QS    = 6'b01_0000;
  localparam status_t SB_SOD   = 6'b10_0000;

  // Request opcodes.
  localparam logic OP_CONTROL = 1'b0;
  localparam logic OP_FAULT   = 1'b1;

  // One request as captured in the input register.
  typedef struct packed {
    logic op;
    logic cmd_switch_on;
    logic cmd_enable_voltage;
    logic cmd_quick_stop;
    logic cmd_enable_operation;
    logic cmd_fault_reset;
  } request_t;

  // Architectural state carried from one request to the next.
  typedef struct packed {
    state_t  machine_state;
    status_t status_bits;
    logic    pid_flag;
    logic    quick_stop_flag;
    logic    prev_fault_reset;
  } drive_state_t;

endpackage

`default_nettype wire

>>> rtl/dpsm_if.sv
// Valid/ready channel interfaces for requests and results of the drive power
// state machine. Depends on nothing.
`default_nettype none

interface dpsm_req_if;
  logic valid;
  logic ready;
  logic op;
  logic cmd_switch_on;
  logic cmd_enable_voltage;
  logic cmd_quick_stop;
  logic cmd_enable_operation;
  logic cmd_fault_reset;

  modport source (
    output valid, op, cmd_switch_on, cmd_enable_voltage, cmd_quick_stop,
           cmd_enable_operation, cmd_fault_reset,
    input  ready
  );
  modport sink (
    input  valid, op, cmd_switch_on, cmd_enable_voltage, cmd_quick_stop,
           cmd_enable_operation, cmd_fault_reset,
    output ready
  );
endinterface

interface dpsm_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] state_code;
  logic       sts_ready_to_switch_on;
  logic       sts_switched_on;
  logic       sts_operation_enabled;
  logic       sts_fault;
  logic       sts_quick_stop;
  logic       sts_switch_on_disabled;
  logic       pid_enable;
  logic       quick_stop_enable;

  modport source (
    output valid, state_code, sts_ready_to_switch_on, sts_switched_on,
           sts_operation_enabled, sts_fault, sts_quick_stop,
           sts_switch_on_disabled, pid_enable, quick_stop_enable,
    input  ready
  );
  modport sink (
    input  valid, state_code, sts_ready_to_switch_on, sts_switched_on,
           sts_operation_enabled, sts_fault, sts_quick_stop,
           sts_switch_on_disabled, pid_enable, quick_stop_enable,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/dpsm_next.sv
// Next-state logic of the drive power state machine: decodes the control
// word and computes the state after one request. Depends on dpsm_pkg.
`default_nettype none

module dpsm_next (
  input  dpsm_pkg::request_t     req,
  input  dpsm_pkg::drive_state_t cur,
  output dpsm_pkg::drive_state_t nxt
);

  logic c_shutdown;
  logic c_switch_on;
  logic c_enable_op;
  logic c_disable_op;
  logic c_disable_v;
  logic c_qstop;
  logic c_fault_reset;
  dpsm_pkg::status_t qs_kept;

  // Control word command decoding.
  always_comb begin
    c_shutdown    = !req.cmd_switch_on && req.cmd_enable_voltage && req.cmd_quick_stop
                    && !req.cmd_fault_reset;
    c_switch_on   = req.cmd_switch_on && req.cmd_enable_voltage && req.cmd_quick_stop
                    && !req.cmd_fault_reset;
    c_enable_op   = c_switch_on && req.cmd_enable_operation;
    c_disable_op  = c_switch_on && !req.cmd_enable_operation;
    c_disable_v   = !req.cmd_enable_voltage && !req.cmd_fault_reset;
    c_qstop       = req.cmd_enable_voltage && !req.cmd_quick_stop && !req.cmd_fault_reset;
    c_fault_reset = req.cmd_fault_reset && !cur.prev_fault_reset;
    qs_kept       = cur.status_bits & dpsm_pkg::SB_QS;
  end

  // State transitions. Unlisted commands only record the fault reset bit.
  always_comb begin
    nxt = cur;
    if (req.op == dpsm_pkg::OP_FAULT) begin
      nxt.quick_stop_flag = 1'b0;
      nxt.pid_flag        = 1'b0;
      nxt.status_bits     = qs_kept | dpsm_pkg::SB_RTSO | dpsm_pkg::SB_SO
                            | dpsm_pkg::SB_OE | dpsm_pkg::SB_FAULT;
      nxt.machine_state   = dpsm_pkg::ST_FAULT_REACT;
    end else begin
      case (cur.machine_state)
        dpsm_pkg::ST_NOT_READY: begin
          nxt.status_bits   = qs_kept | dpsm_pkg::SB_SOD;
          nxt.machine_state = dpsm_pkg::ST_DISABLED;
        end
        dpsm_pkg::ST_DISABLED: begin
          if (c_shutdown) begin
            nxt.status_bits   = dpsm_pkg::SB_RTSO | dpsm_pkg::SB_QS;
            nxt.machine_state = dpsm_pkg::ST_READY;
          end
        end
        dpsm_pkg::ST_READY: begin
          if (c_switch_on) begin
            nxt.status_bits   = dpsm_pkg::SB_RTSO | dpsm_pkg::SB_SO | dpsm_pkg::SB_QS;
            nxt.machine_state = dpsm_pkg::ST_SWITCHED_ON;
          end else if (c_disable_v || c_qstop) begin
            nxt.status_bits   = qs_kept | dpsm_pkg::SB_SOD;
            nxt.machine_state = dpsm_pkg::ST_DISABLED;
          end
        end
        dpsm_pkg::ST_SWITCHED_ON: begin
          if (c_enable_op) begin
            nxt.status_bits   = dpsm_pkg::SB_RTSO | dpsm_pkg::SB_SO | dpsm_pkg::SB_OE
                                | dpsm_pkg::SB_QS;
            nxt.machine_state = dpsm_pkg::ST_OP_ENABLED;
            nxt.pid_flag      = 1'b1;
          end else if (c_disable_v || c_qstop) begin
            nxt.status_bits   = qs_kept | dpsm_pkg::SB_SOD;
            nxt.machine_state = dpsm_pkg::ST_DISABLED;
          end else if (c_shutdown) begin
            nxt.status_bits   = dpsm_pkg::SB_RTSO | dpsm_pkg::SB_QS;
            nxt.machine_state = dpsm_pkg::ST_READY;
          end
        end
        dpsm_pkg::ST_OP_ENABLED: begin
          if (c_qstop) begin
            nxt.status_bits     = dpsm_pkg::SB_RTSO | dpsm_pkg::SB_SO | dpsm_pkg::SB_OE;
            nxt.quick_stop_flag = 1'b1;
            nxt.machine_state   = dpsm_pkg::ST_QSTOP;
          end else if (c_disable_op) begin
            nxt.status_bits   = dpsm_pkg::SB_RTSO | dpsm_pkg::SB_SO | dpsm_pkg::SB_QS;
            nxt.machine_state = dpsm_pkg::ST_SWITCHED_ON;
            nxt.pid_flag      = 1'b0;
          end else if (c_shutdown) begin
            nxt.status_bits   = dpsm_pkg::SB_RTSO | dpsm_pkg::SB_QS;
            nxt.machine_state = dpsm_pkg::ST_READY;
            nxt.pid_flag      = 1'b0;
          end else if (c_disable_v) begin
            nxt.status_bits   = qs_kept | dpsm_pkg::SB_SOD;
            nxt.machine_state = dpsm_pkg::ST_DISABLED;
            nxt.pid_flag      = 1'b0;
          end
        end
        dpsm_pkg::ST_QSTOP: begin
          if (c_disable_v) begin
            nxt.status_bits     = qs_kept | dpsm_pkg::SB_SOD;
            nxt.machine_state   = dpsm_pkg::ST_DISABLED;
            nxt.quick_stop_flag = 1'b0;
            nxt.pid_flag        = 1'b0;
          end else if (c_enable_op) begin
            nxt.status_bits     = dpsm_pkg::SB_RTSO | dpsm_pkg::SB_SO | dpsm_pkg::SB_OE
                                  | dpsm_pkg::SB_QS;
            nxt.machine_state   = dpsm_pkg::ST_OP_ENABLED;
            nxt.quick_stop_flag = 1'b0;
          end
        end
        dpsm_pkg::ST_FAULT_REACT: begin
          nxt.status_bits   = qs_kept | dpsm_pkg::SB_FAULT;
          nxt.machine_state = dpsm_pkg::ST_FAULT;
        end
        dpsm_pkg::ST_FAULT: begin
          if (c_fault_reset) begin
            nxt.status_bits   = qs_kept | dpsm_pkg::SB_SOD;
            nxt.machine_state = dpsm_pkg::ST_DISABLED;
          end
        end
        default: begin
          // Start state: the first control word moves on to not ready.
          nxt.status_bits   = qs_kept;
          nxt.machine_state = dpsm_pkg::ST_NOT_READY;
        end
      endcase
      nxt.prev_fault_reset = req.cmd_fault_reset;
    end
  end

endmodule

`default_nettype wire

>>> rtl/drive_power_state_machine_top.sv
// Top level of the drive power state machine: input register, next-state
// logic and result register. Depends on dpsm_pkg, dpsm_if and dpsm_next.
//
//   Channel  Direction  Carries
//   req      in         op and five control word bits, one request per tick when not stalled
//   rsp      out        state code, six status word bits, two drive flags
//
// Each request passes through the input register and then the result register.
// One request is accepted every cycle unless a stalled result has filled both
// registers; the state register is the only loop.
// Reset puts the machine in the start state with all status bits and flags low.
// A stalled result holds the result register and, once the input register is
// full as well, req.ready drops in the same cycle.
`default_nettype none

module drive_power_state_machine_top (
  input  wire logic   clk,
  input  wire logic   rst,
  dpsm_req_if.sink    req,
  dpsm_rsp_if.source  rsp
);

  dpsm_pkg::request_t     in_data;
  logic                   in_valid;
  dpsm_pkg::drive_state_t cur;
  dpsm_pkg::drive_state_t nxt;
  dpsm_pkg::drive_state_t result;
  logic                   out_valid;
  logic                   advance;

  // The input register moves on when the result register is free or drains.
  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_data <= '{op:                   req.op,
                   cmd_switch_on:        req.cmd_switch_on,
                   cmd_enable_voltage:   req.cmd_enable_voltage,
                   cmd_quick_stop:       req.cmd_quick_stop,
                   cmd_enable_operation: req.cmd_enable_operation,
                   cmd_fault_reset:      req.cmd_fault_reset};
    end
  end

  dpsm_next u_next (
    .req (in_data),
    .cur (cur),
    .nxt (nxt)
  );

  // Machine state, updated once per request as it leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '{machine_state:    dpsm_pkg::ST_START,
               status_bits:      '0,
               pid_flag:         1'b0,
               quick_stop_flag:  1'b0,
               prev_fault_reset: 1'b0};
    end else if (in_valid && advance) begin
      cur <= nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      result <= nxt;
    end
  end

  assign rsp.valid                  = out_valid;
  assign rsp.state_code             = result.machine_state;
  assign rsp.sts_ready_to_switch_on = result.status_bits[0];
  assign rsp.sts_switched_on        = result.status_bits[1];
  assign rsp.sts_operation_enabled  = result.status_bits[2];
  assign rsp.sts_fault              = result.status_bits[3];
  assign rsp.sts_quick_stop         = result.status_bits[4];
  assign rsp.sts_switch_on_disabled = result.status_bits[5];
  assign rsp.pid_enable             = result.pid_flag;
  assign rsp.quick_stop_enable      = result.quick_stop_flag;

endmodule

`default_nettype wire

>>> rtl/dpsm_checker.sv
// Port-level checks for the drive power state machine, bound to the top
// level. Depends on dpsm_pkg and drive_power_state_machine_top.
`default_nettype none

module dpsm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [3:0] state_code,
  input wire logic       sts_fault,
  input wire logic       sts_quick_stop,
  input wire logic       pid_enable,
  input wire logic       quick_stop_enable
);

  // The fault bit is only reported in fault reaction or fault.
  a_fault_state: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && sts_fault |-> state_code == dpsm_pkg::ST_FAULT_REACT
                               || state_code == dpsm_pkg::ST_FAULT)
    else $error("fault bit outside the fault states");

  // The position loop runs only with operation enabled or during quick stop.
  a_pid_state: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && pid_enable |-> state_code == dpsm_pkg::ST_OP_ENABLED
                                || state_code == dpsm_pkg::ST_QSTOP)
    else $error("position loop enabled in a wrong state");

  // The quick stop ramp runs only in quick stop, with the status bit low.
  a_qstop_state: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && quick_stop_enable |-> state_code == dpsm_pkg::ST_QSTOP
                                       && !sts_quick_stop)
    else $error("quick stop ramp flag inconsistent with state");

  // A stalled result keeps its state code.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(state_code))
    else $error("stalled result changed");

endmodule

bind drive_power_state_machine_top dpsm_checker u_dpsm_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .state_code        (rsp.state_code),
  .sts_fault         (rsp.sts_fault),
  .sts_quick_stop    (rsp.sts_quick_stop),
  .pid_enable        (rsp.pid_enable),
  .quick_stop_enable (rsp.quick_stop_enable)
);

`default_nettype wire

>>> test/drive_power_state_machine_top_tb.sv
// Self-checking testbench for the drive power state machine top level.
// Needs dpsm_pkg, the dpsm_req_if and dpsm_rsp_if interfaces and the RTL top.
`timescale 1ns / 1ps

module drive_power_state_machine_top_tb;
  import dpsm_pkg::*;

  // One status report as the block returns it.
  typedef struct packed {
    logic [3:0] code;
    status_t    sts;
    logic       pid;
    logic       qse;
  } drive_report_t;

  // One row of the directed table; typed rows carry their report by hand.
  typedef struct packed {
    request_t      req;
    logic          typed;
    drive_report_t want;
  } stim_row_t;

  // Kinds of control word that the random part draws from.
  typedef enum int {
    K_SHUTDOWN,
    K_SWITCH_ON,
    K_ENABLE_OP,
    K_DISABLE_OP,
    K_DISABLE_V,
    K_QSTOP,
    K_FAULT_RESET,
    K_RAW,
    K_FAULT
  } cmd_kind_t;

  localparam int unsigned ResetCycles = 12;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TimeoutNs   = 2_000_000;
  localparam int unsigned MaxPrinted  = 50;
  localparam int unsigned RandomA     = 475;
  localparam int unsigned RandomB     = 475;
  localparam int unsigned RandomC     = 474;
  localparam int unsigned DirRows     = 25;

  // Status patterns of the powered states.
  localparam status_t PatReady = SB_RTSO | SB_QS;
  localparam status_t PatSwOn  = PatReady | SB_SO;
  localparam status_t PatOpEn  = PatSwOn | SB_OE;

  // Fixed control words used by the directed table.
  localparam request_t RQ_ALL_ZERO   = '{OP_CONTROL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam request_t RQ_ALL_ONE    = '{OP_CONTROL, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
  localparam request_t RQ_SHUTDOWN   = '{OP_CONTROL, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
  localparam request_t RQ_SWITCH_ON  = '{OP_CONTROL, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
  localparam request_t RQ_DISABLE_OP = '{OP_CONTROL, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
  localparam request_t RQ_ENABLE_OP  = '{OP_CONTROL, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
  localparam request_t RQ_DISABLE_V  = '{OP_CONTROL, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam request_t RQ_QSTOP      = '{OP_CONTROL, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam request_t RQ_FAULT_RST  = '{OP_CONTROL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam request_t RQ_FAULT      = '{OP_FAULT, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

  localparam drive_report_t NoReport = '0;

  // Walk through every power state and many of the transitions, then through
  // the fault path, including a fault reset held high without an edge.
  localparam stim_row_t DirTable [DirRows] = '{
    '{RQ_ALL_ZERO,   1'b1, '{ST_NOT_READY, 6'b000000, 1'b0, 1'b0}},
    '{RQ_ALL_ONE,    1'b1, '{ST_DISABLED, 6'b100000, 1'b0, 1'b0}},
    '{RQ_SHUTDOWN,   1'b0, NoReport},
    '{RQ_SWITCH_ON,  1'b0, NoReport},
    '{RQ_ENABLE_OP,  1'b0, NoReport},
    '{RQ_QSTOP,      1'b0, NoReport},
    '{RQ_ENABLE_OP,  1'b0, NoReport},
    '{RQ_QSTOP,      1'b0, NoReport},
    '{RQ_DISABLE_V,  1'b0, NoReport},
    '{RQ_SHUTDOWN,   1'b0, NoReport},
    '{RQ_SWITCH_ON,  1'b0, NoReport},
    '{RQ_ENABLE_OP,  1'b0, NoReport},
    '{RQ_DISABLE_OP, 1'b0, NoReport},
    '{RQ_ENABLE_OP,  1'b0, NoReport},
    '{RQ_SHUTDOWN,   1'b0, NoReport},
    '{RQ_QSTOP,      1'b0, NoReport},
    '{RQ_SHUTDOWN,   1'b0, NoReport},
    '{RQ_SWITCH_ON,  1'b0, NoReport},
    '{RQ_ENABLE_OP,  1'b0, NoReport},
    '{RQ_FAULT,      1'b1, '{ST_FAULT_REACT, 6'b011111, 1'b0, 1'b0}},
    '{RQ_ALL_ONE,    1'b1, '{ST_FAULT, 6'b011000, 1'b0, 1'b0}},
    '{RQ_FAULT_RST,  1'b0, NoReport},
    '{RQ_FAULT,      1'b1, '{ST_FAULT_REACT, 6'b011111, 1'b0, 1'b0}},
    '{RQ_ALL_ZERO,   1'b1, '{ST_FAULT, 6'b011000, 1'b0, 1'b0}},
    '{RQ_FAULT_RST,  1'b1, '{ST_DISABLED, 6'b110000, 1'b0, 1'b0}}
  };

  logic clk;
  logic rst = 1'b1;

  dpsm_req_if req_bus ();
  dpsm_rsp_if rsp_bus ();

  drive_power_state_machine_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Predicted drive state, starting from the reset values.
  state_t  drv_state   = ST_START;
  status_t drv_status  = '0;
  logic    drv_pid     = 1'b0;
  logic    drv_qstop   = 1'b0;
  logic    drv_prev_fr = 1'b0;

  drive_report_t reports_due [$];
  int unsigned   mismatch_count = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_kick = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Apply one request to the predicted drive state and return the new report.
  function automatic drive_report_t advance_drive(input request_t r);
    logic    c_shutdown, c_switch_on, c_enable_op, c_disable_op;
    logic    c_disable_v, c_qstop, c_fault_reset;
    status_t pat_disabled;
    pat_disabled = (drv_status & SB_QS) | SB_SOD;
    if (r.op == OP_FAULT) begin
      drv_qstop  = 1'b0;
      drv_pid    = 1'b0;
      drv_status = (drv_status & SB_QS) | SB_RTSO | SB_SO | SB_OE | SB_FAULT;
      drv_state  = ST_FAULT_REACT;
    end else begin
      c_shutdown   = !r.cmd_switch_on && r.cmd_enable_voltage && r.cmd_quick_stop &&
                     !r.cmd_fault_reset;
      c_switch_on  = r.cmd_switch_on && r.cmd_enable_voltage && r.cmd_quick_stop &&
                     !r.cmd_fault_reset;
      c_enable_op  = c_switch_on && r.cmd_enable_operation;
      c_disable_op = c_switch_on && !r.cmd_enable_operation;
      c_disable_v  = !r.cmd_enable_voltage && !r.cmd_fault_reset;
      c_qstop      = r.cmd_enable_voltage && !r.cmd_quick_stop && !r.cmd_fault_reset;
      c_fault_reset = r.cmd_fault_reset && !drv_prev_fr;
      case (drv_state)
        ST_NOT_READY: begin
          drv_status = pat_disabled;
          drv_state  = ST_DISABLED;
        end
        ST_DISABLED: begin
          if (c_shutdown) begin
            drv_status = PatReady;
            drv_state  = ST_READY;
          end
        end
        ST_READY: begin
          if (c_switch_on) begin
            drv_status = PatSwOn;
            drv_state  = ST_SWITCHED_ON;
          end else if (c_disable_v || c_qstop) begin
            drv_status = pat_disabled;
            drv_state  = ST_DISABLED;
          end
        end
        ST_SWITCHED_ON: begin
          if (c_enable_op) begin
            drv_status = PatOpEn;
            drv_state  = ST_OP_ENABLED;
            drv_pid    = 1'b1;
          end else if (c_disable_v || c_qstop) begin
            drv_status = pat_disabled;
            drv_state  = ST_DISABLED;
          end else if (c_shutdown) begin
            drv_status = PatReady;
            drv_state  = ST_READY;
          end
        end
        ST_OP_ENABLED: begin
          if (c_qstop) begin
            drv_status = SB_RTSO | SB_SO | SB_OE;
            drv_qstop  = 1'b1;
            drv_state  = ST_QSTOP;
          end else if (c_disable_op) begin
            drv_status = PatSwOn;
            drv_state  = ST_SWITCHED_ON;
            drv_pid    = 1'b0;
          end else if (c_shutdown) begin
            drv_status = PatReady;
            drv_state  = ST_READY;
            drv_pid    = 1'b0;
          end else if (c_disable_v) begin
            drv_status = pat_disabled;
            drv_state  = ST_DISABLED;
            drv_pid    = 1'b0;
          end
        end
        ST_QSTOP: begin
          if (c_disable_v) begin
            drv_status = pat_disabled;
            drv_state  = ST_DISABLED;
            drv_qstop  = 1'b0;
            drv_pid    = 1'b0;
          end else if (c_enable_op) begin
            drv_status = PatOpEn;
            drv_state  = ST_OP_ENABLED;
            drv_qstop  = 1'b0;
          end
        end
        ST_FAULT_REACT: begin
          drv_status = (drv_status & SB_QS) | SB_FAULT;
          drv_state  = ST_FAULT;
        end
        ST_FAULT: begin
          if (c_fault_reset) begin
            drv_status = pat_disabled;
            drv_state  = ST_DISABLED;
          end
        end
        default: begin
          drv_status = drv_status & SB_QS;
          drv_state  = ST_NOT_READY;
        end
      endcase
      // The fault reset edge is judged against the previous control word.
      drv_prev_fr = r.cmd_fault_reset;
    end
    return '{drv_state, drv_status, drv_pid, drv_qstop};
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MaxPrinted) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Offer one request, wait for it to be taken, then record its expected report.
  task automatic offer_request(input request_t r, input logic typed,
                               input drive_report_t typed_want);
    drive_report_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid                <= 1'b1;
    req_bus.op                   <= r.op;
    req_bus.cmd_switch_on        <= r.cmd_switch_on;
    req_bus.cmd_enable_voltage   <= r.cmd_enable_voltage;
    req_bus.cmd_quick_stop       <= r.cmd_quick_stop;
    req_bus.cmd_enable_operation <= r.cmd_enable_operation;
    req_bus.cmd_fault_reset      <= r.cmd_fault_reset;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predicted = advance_drive(r);
    reports_due.push_back(typed ? typed_want : predicted);
  endtask

  // Stop offering and wait until every outstanding report has come back.
  task automatic pause_until_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (reports_due.size() != 0);
  endtask

  // Random control words, steered towards the command that moves the drive on
  // from its present state so that the deeper states are reached often.
  task automatic run_random(input int unsigned count);
    request_t  r;
    cmd_kind_t kind;
    int unsigned roll;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        kind = K_FAULT;
      end else if (roll < 14) begin
        kind = K_RAW;
      end else if (roll < 60) begin
        case (drv_state)
          ST_DISABLED:    kind = K_SHUTDOWN;
          ST_READY:       kind = K_SWITCH_ON;
          ST_SWITCHED_ON: kind = K_ENABLE_OP;
          ST_OP_ENABLED:  kind = $urandom_range(1) ? K_QSTOP : K_DISABLE_OP;
          ST_QSTOP:       kind = $urandom_range(1) ? K_ENABLE_OP : K_DISABLE_V;
          ST_FAULT:       kind = drv_prev_fr ? K_DISABLE_V : K_FAULT_RESET;
          default:        kind = K_RAW;
        endcase
      end else begin
        kind = cmd_kind_t'($urandom_range(K_FAULT_RESET));
      end

      // Bits that the chosen command does not fix stay random.
      r = request_t'(6'($urandom));
      r.op = OP_CONTROL;
      case (kind)
        K_SHUTDOWN: begin
          r.cmd_switch_on      = 1'b0;
          r.cmd_enable_voltage = 1'b1;
          r.cmd_quick_stop     = 1'b1;
          r.cmd_fault_reset    = 1'b0;
        end
        K_SWITCH_ON, K_ENABLE_OP, K_DISABLE_OP: begin
          r.cmd_switch_on      = 1'b1;
          r.cmd_enable_voltage = 1'b1;
          r.cmd_quick_stop     = 1'b1;
          r.cmd_fault_reset    = 1'b0;
          if (kind == K_ENABLE_OP) r.cmd_enable_operation = 1'b1;
          if (kind == K_DISABLE_OP) r.cmd_enable_operation = 1'b0;
        end
        K_DISABLE_V: begin
          r.cmd_enable_voltage = 1'b0;
          r.cmd_fault_reset    = 1'b0;
        end
        K_QSTOP: begin
          r.cmd_enable_voltage = 1'b1;
          r.cmd_quick_stop     = 1'b0;
          r.cmd_fault_reset    = 1'b0;
        end
        K_FAULT_RESET: r.cmd_fault_reset = 1'b1;
        K_FAULT: r.op = OP_FAULT;
        default: ;
      endcase
      offer_request(r, 1'b0, NoReport);
    end
  endtask

  // Result side: held off in reset, then random back-pressure, or a long
  // hold-off when one is kicked.
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_kick != hold_seen) begin
      hold_seen     <= hold_kick;
      hold_left     <= HoldCycles;
      rsp_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted report with the oldest one outstanding.
  always @(posedge clk) begin : check_reports
    drive_report_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (reports_due.size() == 0) begin
        report_mismatch($sformatf("report with none outstanding, state_code %h",
                                  rsp_bus.state_code));
      end else begin
        want = reports_due.pop_front();
        if (rsp_bus.state_code !== want.code)
          report_mismatch($sformatf("state_code %h, expected %h",
                                    rsp_bus.state_code, want.code));
        if (rsp_bus.sts_ready_to_switch_on !== |(want.sts & SB_RTSO))
          report_mismatch($sformatf("sts_ready_to_switch_on %b, expected %b",
                                    rsp_bus.sts_ready_to_switch_on, |(want.sts & SB_RTSO)));
        if (rsp_bus.sts_switched_on !== |(want.sts & SB_SO))
          report_mismatch($sformatf("sts_switched_on %b, expected %b",
                                    rsp_bus.sts_switched_on, |(want.sts & SB_SO)));
        if (rsp_bus.sts_operation_enabled !== |(want.sts & SB_OE))
          report_mismatch($sformatf("sts_operation_enabled %b, expected %b",
                                    rsp_bus.sts_operation_enabled, |(want.sts & SB_OE)));
        if (rsp_bus.sts_fault !== |(want.sts & SB_FAULT))
          report_mismatch($sformatf("sts_fault %b, expected %b",
                                    rsp_bus.sts_fault, |(want.sts & SB_FAULT)));
        if (rsp_bus.sts_quick_stop !== |(want.sts & SB_QS))
          report_mismatch($sformatf("sts_quick_stop %b, expected %b",
                                    rsp_bus.sts_quick_stop, |(want.sts & SB_QS)));
        if (rsp_bus.sts_switch_on_disabled !== |(want.sts & SB_SOD))
          report_mismatch($sformatf("sts_switch_on_disabled %b, expected %b",
                                    rsp_bus.sts_switch_on_disabled, |(want.sts & SB_SOD)));
        if (rsp_bus.pid_enable !== want.pid)
          report_mismatch($sformatf("pid_enable %b, expected %b",
                                    rsp_bus.pid_enable, want.pid));
        if (rsp_bus.quick_stop_enable !== want.qse)
          report_mismatch($sformatf("quick_stop_enable %b, expected %b",
                                    rsp_bus.quick_stop_enable, want.qse));
      end
    end
  end

  // Stimulus: reset, the directed table, then three random phases.
  initial begin : stimulus
    req_bus.valid                <= 1'b0;
    req_bus.op                   <= OP_CONTROL;
    req_bus.cmd_switch_on        <= 1'b0;
    req_bus.cmd_enable_voltage   <= 1'b0;
    req_bus.cmd_quick_stop       <= 1'b0;
    req_bus.cmd_enable_operation <= 1'b0;
    req_bus.cmd_fault_reset      <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // Slow sender against a mostly stalled receiver.
    send_idle_pct = 17;
    recv_idle_pct <= 82;
    for (int unsigned i = 0; i < DirRows; i++) begin
      offer_request(DirTable[i].req, DirTable[i].typed, DirTable[i].want);
    end
    run_random(RandomA);
    pause_until_drained();

    // Mostly idle sender against an eager receiver.
    send_idle_pct = 82;
    recv_idle_pct <= 17;
    run_random(RandomB);
    pause_until_drained();

    // Full rate, starting with a long receiver hold-off so the block backs up.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_kick <= ~hold_kick;
    run_random(RandomC);
    pause_until_drained();

    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("drive_power_state_machine_top verification clean");
    end else begin
      $display("drive_power_state_machine_top verification failed");
    end
    $finish;
  end

  // Watchdog in case the block stops answering.
  initial begin
    #(TimeoutNs);
    $display("drive_power_state_machine_top verification failed");
    $finish;
  end

endmodule
